// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the rotator block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/core/fbvr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbvr_pkg
// Types, angle constants and the arctangent table of the velocity rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbvr_pkg;

    localparam int HEAD_WIDTH = 24;
    localparam int LOW_BITS   = 11;   // 360 deg * 256 = 45 * 2^11
    localparam int ZW         = 26;   // residual angle, 2^-16 degree units
    localparam int TABLE_LEN  = 24;
    localparam int MOD_SHIFT  = 17;

    typedef logic signed [ZW-1:0] t_z;
    typedef logic signed [31:0]   t_vec;   // CORDIC vector, Q2.30
    typedef logic signed [17:0]   t_ang;   // heading in 1/256 degree

    localparam t_ang FULL_TURN    = 18'sd92160;
    localparam t_ang HALF_TURN    = 18'sd46080;
    localparam t_ang QUARTER_TURN = 18'sd23040;
    localparam t_z   Z_LIMIT      = 26'sd5898240;
    localparam t_vec GAIN_Q30     = 32'sd652032874;

    // Heading blocks of 2^11 are reduced modulo 45 through a reciprocal.
    localparam logic [13:0] MOD_OFFSET  = 14'd4140;   // 92 * 45
    localparam logic [11:0] MOD_RECIP   = 12'd2913;   // ceil(2^17 / 45)
    localparam logic [13:0] TURN_BLOCKS = 14'd45;

    // round(atan(2^-i) in degrees * 2^16)
    function automatic t_z atan_deg16(input logic [4:0] idx);
        t_z v;
        unique case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fbvr_if.sv =====
// ----------------------------------------------------------------------------
// fbvr_if
// Valid/ready channels that carry input and result items of the rotator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fbvr_in_if #(
    parameter int VEL_WIDTH = 16
);
    logic                                   valid;
    logic                                   ready;
    logic signed [VEL_WIDTH-1:0]            field_vx;
    logic signed [VEL_WIDTH-1:0]            field_vy;
    logic signed [VEL_WIDTH-1:0]            turn_rate;
    logic signed [fbvr_pkg::HEAD_WIDTH-1:0] heading;
    logic                                   gyro_present;

    modport source (
        output valid, field_vx, field_vy, turn_rate, heading, gyro_present,
        input  ready
    );
    modport sink (
        input  valid, field_vx, field_vy, turn_rate, heading, gyro_present,
        output ready
    );
endinterface

interface fbvr_out_if #(
    parameter int VEL_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VEL_WIDTH-1:0] body_vx;
    logic signed [VEL_WIDTH-1:0] body_vy;
    logic signed [VEL_WIDTH-1:0] body_turn_rate;

    modport source (
        output valid, body_vx, body_vy, body_turn_rate,
        input  ready
    );
    modport sink (
        input  valid, body_vx, body_vy, body_turn_rate,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/field_to_body_velocity_rotator_top.sv =====
// ----------------------------------------------------------------------------
// field_to_body_velocity_rotator_top
// Rotates a field-frame velocity into the body frame by the gyro heading.
// ----------------------------------------------------------------------------
// Use: an item on i_in carries field_vx, field_vy, turn_rate (signed Q8.8),
// heading (1/256 degree, any number of turns) and gyro_present. For each
// item exactly one result leaves on o_out: body_vx and body_vy are the
// velocity rotated by +heading and saturated, body_turn_rate is a copy.
// Without a gyro the heading counts as zero.
// The heading is reduced and folded in stages A, B and C, then the CORDIC
// runs one iteration per stage, stage D fixes the sign, E multiplies, and
// F sums with rounding into the output register.
// Throughput is one item per cycle while o_out does not stall; every stage
// is a register stage and the CORDIC has one unrolled iteration per stage.
// Reset clears all valid bits; the block holds no other state.
// When o_out is stalled with a result waiting, the whole pipeline freezes
// and i_in.ready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module field_to_body_velocity_rotator_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int VEL_WIDTH     = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fbvr_in_if.sink         i_in,
    fbvr_out_if.source      o_out
);

    localparam int NS = (CORDIC_STAGES < fbvr_pkg::TABLE_LEN)
                        ? CORDIC_STAGES : fbvr_pkg::TABLE_LEN;
    localparam int VW = VEL_WIDTH;
    localparam int PW = VW + 33;   // velocity times signed 33-bit coefficient
    localparam int AW = VW + 34;   // sum of two products
    localparam int LB = fbvr_pkg::LOW_BITS;

    localparam logic signed [AW-1:0] RND    = {{(AW-30){1'b0}}, 1'b1, {29{1'b0}}};
    localparam logic signed [AW-1:0] SAT_HI = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    typedef logic signed [VW-1:0] t_vel;

    logic w_en;

    // ------------------------------------------------------------------
    // Stage A: heading split into 2^11 blocks, reciprocal multiply by 1/45.
    // ------------------------------------------------------------------
    logic [fbvr_pkg::HEAD_WIDTH-1:0] w_hd;
    logic [13:0]                     w_u;
    logic                            r_a_vld;
    logic [13:0]                     r_a_u;
    logic [LB-1:0]                   r_a_low;
    logic [25:0]                     r_a_prod;
    t_vel                            r_a_vx, r_a_vy, r_a_tr;

    assign w_hd = i_in.gyro_present ? i_in.heading : '0;
    // The offset is a multiple of 45, so the block index stays positive.
    assign w_u  = {w_hd[fbvr_pkg::HEAD_WIDTH-1], w_hd[fbvr_pkg::HEAD_WIDTH-1:LB]}
                  + fbvr_pkg::MOD_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_u    <= w_u;
            r_a_low  <= w_hd[LB-1:0];
            r_a_prod <= w_u * fbvr_pkg::MOD_RECIP;
            r_a_vx   <= i_in.field_vx;
            r_a_vy   <= i_in.field_vy;
            r_a_tr   <= i_in.turn_rate;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: remainder modulo 45 gives the heading in [0, 92160).
    // ------------------------------------------------------------------
    logic [7:0]  w_qt;
    logic [13:0] w_m;
    logic        r_b_vld;
    logic [16:0] r_b_r;
    t_vel        r_b_vx, r_b_vy, r_b_tr;

    assign w_qt = r_a_prod[fbvr_pkg::MOD_SHIFT +: 8];
    assign w_m  = r_a_u - 14'(w_qt) * fbvr_pkg::TURN_BLOCKS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_r  <= {w_m[5:0], r_a_low};
            r_b_vx <= r_a_vx;
            r_b_vy <= r_a_vy;
            r_b_tr <= r_a_tr;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: center on zero, fold into [-90, +90] degrees.
    // ------------------------------------------------------------------
    fbvr_pkg::t_ang w_rpos, w_rs, w_fold;
    logic           w_flip;
    logic           r_c_vld;
    fbvr_pkg::t_z   r_c_z;
    logic           r_c_flip;
    t_vel           r_c_vx, r_c_vy, r_c_tr;

    assign w_rpos = {1'b0, r_b_r};
    assign w_rs   = (w_rpos >= fbvr_pkg::HALF_TURN) ? w_rpos - fbvr_pkg::FULL_TURN
                                                    : w_rpos;

    always_comb begin
        w_fold = w_rs;
        w_flip = 1'b0;
        if (w_rs > fbvr_pkg::QUARTER_TURN) begin
            w_fold = w_rs - fbvr_pkg::HALF_TURN;
            w_flip = 1'b1;
        end else if (w_rs < -fbvr_pkg::QUARTER_TURN) begin
            w_fold = w_rs + fbvr_pkg::HALF_TURN;
            w_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_z    <= {w_fold, 8'b0};
            r_c_flip <= w_flip;
            r_c_vx   <= r_b_vx;
            r_c_vy   <= r_b_vy;
            r_c_tr   <= r_b_tr;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC in rotation mode, one iteration per stage.
    // ------------------------------------------------------------------
    fbvr_pkg::t_vec r_cx   [NS];
    fbvr_pkg::t_vec r_cy   [NS];
    fbvr_pkg::t_z   r_cz   [NS];
    logic           r_cf   [NS];
    logic           r_cv   [NS];
    t_vel           r_cvx  [NS];
    t_vel           r_cvy  [NS];
    t_vel           r_ctr  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        fbvr_pkg::t_vec w_xi, w_yi;
        fbvr_pkg::t_z   w_zi;
        logic           w_fi, w_vi;
        t_vel           w_vxi, w_vyi, w_tri;

        if (k == 0) begin : g_first
            assign w_xi  = fbvr_pkg::GAIN_Q30;
            assign w_yi  = '0;
            assign w_zi  = r_c_z;
            assign w_fi  = r_c_flip;
            assign w_vi  = r_c_vld;
            assign w_vxi = r_c_vx;
            assign w_vyi = r_c_vy;
            assign w_tri = r_c_tr;
        end else begin : g_next
            assign w_xi  = r_cx[k-1];
            assign w_yi  = r_cy[k-1];
            assign w_zi  = r_cz[k-1];
            assign w_fi  = r_cf[k-1];
            assign w_vi  = r_cv[k-1];
            assign w_vxi = r_cvx[k-1];
            assign w_vyi = r_cvy[k-1];
            assign w_tri = r_ctr[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else if (w_en) begin
                r_cv[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!w_zi[fbvr_pkg::ZW-1]) begin
                    r_cx[k] <= w_xi - (w_yi >>> k);
                    r_cy[k] <= w_yi + (w_xi >>> k);
                    r_cz[k] <= w_zi - fbvr_pkg::atan_deg16(5'(k));
                end else begin
                    r_cx[k] <= w_xi + (w_yi >>> k);
                    r_cy[k] <= w_yi - (w_xi >>> k);
                    r_cz[k] <= w_zi + fbvr_pkg::atan_deg16(5'(k));
                end
                r_cf[k]  <= w_fi;
                r_cvx[k] <= w_vxi;
                r_cvy[k] <= w_vyi;
                r_ctr[k] <= w_tri;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: undo the fold by negating cos and sin.
    // ------------------------------------------------------------------
    logic signed [32:0] w_cx, w_sy;
    logic               r_d_vld;
    logic signed [32:0] r_d_c, r_d_s;
    t_vel               r_d_vx, r_d_vy, r_d_tr;

    assign w_cx = 33'(r_cx[NS-1]);
    assign w_sy = 33'(r_cy[NS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_cv[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_c  <= r_cf[NS-1] ? -w_cx : w_cx;
            r_d_s  <= r_cf[NS-1] ? -w_sy : w_sy;
            r_d_vx <= r_cvx[NS-1];
            r_d_vy <= r_cvy[NS-1];
            r_d_tr <= r_ctr[NS-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: the four products.
    // ------------------------------------------------------------------
    logic                 r_e_vld;
    logic signed [PW-1:0] r_e_pxc, r_e_pys, r_e_pxs, r_e_pyc;
    t_vel                 r_e_tr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_pxc <= r_d_vx * r_d_c;
            r_e_pys <= r_d_vy * r_d_s;
            r_e_pxs <= r_d_vx * r_d_s;
            r_e_pyc <= r_d_vy * r_d_c;
            r_e_tr  <= r_d_tr;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: sum, round half up out of Q30, saturate; output register.
    // ------------------------------------------------------------------
    logic signed [AW-1:0] w_accx, w_accy, w_shx, w_shy;
    t_vel                 w_satx, w_saty;
    logic                 r_f_vld;
    t_vel                 r_f_vx, r_f_vy, r_f_tr;

    assign w_accx = AW'(r_e_pxc) - AW'(r_e_pys) + RND;
    assign w_accy = AW'(r_e_pxs) + AW'(r_e_pyc) + RND;
    assign w_shx  = w_accx >>> 30;
    assign w_shy  = w_accy >>> 30;

    assign w_satx = (w_shx > SAT_HI) ? SAT_HI[VW-1:0] :
                    (w_shx < SAT_LO) ? SAT_LO[VW-1:0] : w_shx[VW-1:0];
    assign w_saty = (w_shy > SAT_HI) ? SAT_HI[VW-1:0] :
                    (w_shy < SAT_LO) ? SAT_LO[VW-1:0] : w_shy[VW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_vx <= w_satx;
            r_f_vy <= w_saty;
            r_f_tr <= r_e_tr;
        end
    end

    // The pipeline moves whenever the output register is free or taken.
    assign w_en                 = !r_f_vld || o_out.ready;
    assign i_in.ready           = w_en;
    assign o_out.valid          = r_f_vld;
    assign o_out.body_vx        = r_f_vx;
    assign o_out.body_vy        = r_f_vy;
    assign o_out.body_turn_rate = r_f_tr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ANY(a_rst_clear, i_clk, !i_rst_n |=> !o_out.valid, "result valid after reset")
    `ASSERT_RST(a_stall_block, i_clk, i_rst_n, o_out.valid && !o_out.ready |-> !i_in.ready, "input taken during output stall")
    `ASSERT_RST(a_mod_range, i_clk, i_rst_n, r_b_vld |-> r_b_r[16:LB] < 6'd45, "heading remainder out of range")
    `ASSERT_RST(a_fold_range, i_clk, i_rst_n, r_c_vld |-> r_c_z <= fbvr_pkg::Z_LIMIT && r_c_z >= -fbvr_pkg::Z_LIMIT, "folded angle beyond a quarter turn")

endmodule

`default_nettype wire

// ===== sim/fbvr_rotation_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvr_rotation_checker
// Watches both channels of the velocity rotator. It predicts the body-frame
// velocity for every accepted input item and compares each result with it.
// ----------------------------------------------------------------------------

module fbvr_rotation_checker #(
    parameter int CORDIC_STAGES = 16,
    parameter int VEL_WIDTH     = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fbvr_in_if      in_ch,
    fbvr_out_if     out_ch,
    output int      o_failures,
    output int      o_pending
);

    localparam int     ATAN_LEN  = 24;
    localparam longint VEL_MAX   = (64'sd1 <<< (VEL_WIDTH - 1)) - 1;
    localparam longint VEL_MIN   = -VEL_MAX - 1;
    localparam real    DEG_PER_RAD = 57.29577951308232;

    typedef struct packed {
        logic signed [VEL_WIDTH-1:0] vx;
        logic signed [VEL_WIDTH-1:0] vy;
        logic signed [VEL_WIDTH-1:0] rate;
    } body_vel_t;

    body_vel_t body_vel_q[$];
    longint    atan_tab[ATAN_LEN];
    int        fail_count    = 0;
    int        pending_count = 0;

    assign o_failures = fail_count;
    assign o_pending  = pending_count;

    // Arctangent of 2^-i in units of 2^-16 degree, rounded to nearest.
    initial begin : build_atan
        int i;
        for (i = 0; i < ATAN_LEN; i++) begin
            atan_tab[i] = longint'($floor($atan(1.0 / real'(1 << i)) * DEG_PER_RAD
                                          * 65536.0 + 0.5));
        end
    end

    function automatic longint clamp_vel(input longint v);
        if (v > VEL_MAX) return VEL_MAX;
        if (v < VEL_MIN) return VEL_MIN;
        return v;
    endfunction

    function automatic body_vel_t rotate_to_body(
        input logic signed [VEL_WIDTH-1:0]            vx,
        input logic signed [VEL_WIDTH-1:0]            vy,
        input logic signed [VEL_WIDTH-1:0]            rate,
        input logic signed [fbvr_pkg::HEAD_WIDTH-1:0] heading,
        input logic                                   gyro
    );
        longint    full_turn;
        longint    half_turn;
        longint    quarter_turn;
        longint    ang;
        longint    x;
        longint    y;
        longint    z;
        longint    dx;
        longint    dy;
        longint    c;
        longint    s;
        longint    round_bias;
        bit        flip;
        int        i;
        body_vel_t res;

        full_turn    = longint'(fbvr_pkg::FULL_TURN);
        half_turn    = longint'(fbvr_pkg::HALF_TURN);
        quarter_turn = longint'(fbvr_pkg::QUARTER_TURN);
        round_bias   = 64'sd1 <<< 29;
        ang  = 0;
        flip = 1'b0;
        if (gyro) begin
            ang = longint'(heading) % full_turn;
            if (ang < 0) ang += full_turn;
        end
        if (ang >= half_turn) ang -= full_turn;
        // Fold into [-90, +90] degrees; the half-turn shows up as a sign flip.
        if (ang > quarter_turn) begin
            ang -= half_turn;
            flip = 1'b1;
        end else if (ang < -quarter_turn) begin
            ang += half_turn;
            flip = 1'b1;
        end
        z = ang * 256;
        x = longint'(fbvr_pkg::GAIN_Q30);
        y = 0;
        for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        res.vx   = VEL_WIDTH'(clamp_vel((longint'(vx) * c - longint'(vy) * s + round_bias)
                                        >>> 30));
        res.vy   = VEL_WIDTH'(clamp_vel((longint'(vx) * s + longint'(vy) * c + round_bias)
                                        >>> 30));
        res.rate = rate;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        body_vel_t want;
        body_vel_t got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got.vx   = out_ch.body_vx;
                got.vy   = out_ch.body_vy;
                got.rate = out_ch.body_turn_rate;
                if (body_vel_q.size() == 0) begin
                    $display("%0t: result with nothing expected: vx=%0d vy=%0d rate=%0d",
                             $time, got.vx, got.vy, got.rate);
                    fail_count++;
                end else begin
                    want = body_vel_q.pop_front();
                    if (got.vx !== want.vx) begin
                        $display("%0t: body_vx expected %0d, actual %0d",
                                 $time, want.vx, got.vx);
                        fail_count++;
                    end
                    if (got.vy !== want.vy) begin
                        $display("%0t: body_vy expected %0d, actual %0d",
                                 $time, want.vy, got.vy);
                        fail_count++;
                    end
                    if (got.rate !== want.rate) begin
                        $display("%0t: body_turn_rate expected %0d, actual %0d",
                                 $time, want.rate, got.rate);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                body_vel_q.push_back(rotate_to_body(in_ch.field_vx, in_ch.field_vy,
                                                    in_ch.turn_rate, in_ch.heading,
                                                    in_ch.gyro_present));
            end
            pending_count = body_vel_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives field-frame velocity items into the rotator under changing sender
// and receiver idling, with one long output stall, and reports the verdict.
// ----------------------------------------------------------------------------

module testbench;

    localparam int VEL_W       = 16;
    localparam int CORDIC_N    = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * (CORDIC_N + 6);

    logic i_clk;
    logic i_rst_n;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_req      = 1'b0;
    bit   hold_done     = 1'b0;
    int   cycle_count   = 0;
    int   failures;
    int   pending;

    fbvr_in_if  #(.VEL_WIDTH(VEL_W)) in_ch ();
    fbvr_out_if #(.VEL_WIDTH(VEL_W)) out_ch ();

    field_to_body_velocity_rotator_top #(
        .CORDIC_STAGES(CORDIC_N),
        .VEL_WIDTH    (VEL_W)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    fbvr_rotation_checker #(
        .CORDIC_STAGES(CORDIC_N),
        .VEL_WIDTH    (VEL_W)
    ) rotation_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_failures(failures),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off once it is requested.
    initial begin : receiver
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_velocity(
        input logic signed [VEL_W-1:0] vx,
        input logic signed [VEL_W-1:0] vy,
        input logic signed [VEL_W-1:0] rate,
        input logic signed [23:0]      heading,
        input logic                    gyro
    );
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.field_vx     <= vx;
        in_ch.field_vy     <= vy;
        in_ch.turn_rate    <= rate;
        in_ch.heading      <= heading;
        in_ch.gyro_present <= gyro;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic offer_random_velocity();
        logic [31:0]       rnd;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] rate;
        logic signed [23:0] hd;
        logic              gyro;
        int                pick;
        rnd  = $urandom();
        rate = rnd[15:0];
        rnd  = $urandom();
        if ($urandom_range(1, 0) == 0) begin
            vx = rnd[15:0];
            vy = rnd[31:16];
        end else begin
            vx = 16'(int'($urandom_range(4095, 0)) - 2048);
            vy = 16'(int'($urandom_range(4095, 0)) - 2048);
        end
        pick = $urandom_range(99, 0);
        rnd  = $urandom();
        if (pick < 40) begin
            hd = rnd[23:0];
        end else if (pick < 70) begin
            hd = 24'(int'($urandom_range(737280, 0)) - 368640);
        end else begin
            // Just around a multiple of a quarter turn, where folding changes.
            hd = 24'((int'($urandom_range(16, 0)) - 8) * 23040
                     + int'($urandom_range(6, 0)) - 3);
        end
        gyro = ($urandom_range(99, 0) < 85);
        offer_velocity(vx, vy, rate, hd, gyro);
    endtask

    initial begin : stimulus
        int n;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.field_vx     = '0;
        in_ch.field_vy     = '0;
        in_ch.turn_rate    = '0;
        in_ch.heading      = '0;
        in_ch.gyro_present = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 82;
        offer_velocity(16'sd0, 16'sd0, 16'sd0, 24'sd0, 1'b1);
        offer_velocity(16'sd32767, 16'sd0, 16'sd1, 24'sd0, 1'b1);
        offer_velocity(-16'sd32768, -16'sd32768, 16'sd32767, 24'sd0, 1'b1);
        offer_velocity(16'sd256, 16'sd0, -16'sd32768, 24'sd23040, 1'b1);
        offer_velocity(16'sd256, 16'sd512, -16'sd1, -24'sd23040, 1'b1);
        offer_velocity(16'sd1000, -16'sd700, 16'sd5, 24'sd23041, 1'b1);
        offer_velocity(16'sd1000, -16'sd700, 16'sd6, -24'sd23041, 1'b1);
        offer_velocity(16'sd300, 16'sd400, 16'sd7, 24'sd46080, 1'b1);
        offer_velocity(16'sd300, 16'sd400, 16'sd8, -24'sd46080, 1'b1);
        offer_velocity(16'sd300, 16'sd400, 16'sd9, 24'sd92160, 1'b1);
        // At 45 degrees the full-scale sum overflows and must saturate.
        offer_velocity(16'sd32767, 16'sd32767, 16'sd10, 24'sd11520, 1'b1);
        offer_velocity(-16'sd32768, -16'sd32768, 16'sd11, 24'sd11520, 1'b1);
        offer_velocity(16'sd32767, -16'sd32768, 16'sd12, -24'sd34560, 1'b1);
        offer_velocity(16'sd1234, -16'sd4321, 16'sd13, 24'sd8388607, 1'b1);
        offer_velocity(16'sd1234, -16'sd4321, 16'sd14, -24'sd8388608, 1'b1);
        // Without a gyro the heading field must have no effect.
        offer_velocity(16'sd1000, -16'sd2000, 16'sd15, 24'sd11520, 1'b0);
        offer_velocity(16'sd1000, -16'sd2000, 16'sd16, -24'sd1, 1'b0);
        offer_velocity(16'sd2560, 16'sd128, 16'sd17, 24'sd69120, 1'b1);
        offer_velocity(16'sd2560, 16'sd128, 16'sd18, 24'sd1, 1'b1);
        offer_velocity(16'sd2560, 16'sd128, 16'sd19, -24'sd1, 1'b1);
        offer_velocity(16'sd2560, 16'sd128, 16'sd20, 24'sd46079, 1'b1);
        offer_velocity(16'sd2560, 16'sd128, 16'sd21, 24'sd92159, 1'b1);
        for (n = 0; n < 130; n++) offer_random_velocity();

        send_idle_pct = 82;
        recv_idle_pct = 6;
        for (n = 0; n < 130; n++) offer_random_velocity();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (n = 0; n < 140; n++) begin
            // The sender keeps offering while the receiver holds off.
            if (n == 20) hold_req = 1'b1;
            offer_random_velocity();
        end
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
